[sv/afsa_pkg.sv]
// shared types and constants of the aligned first-fit slice allocator
package afsa_pkg;

  localparam int unsigned MaxBuffersDef = 8;
  localparam logic [31:0] MinSizeReset  = 32'd65536;

  typedef enum logic [1:0] {
    ST_GRANT  = 2'd0,
    ST_NOSLOT = 2'd1,
    ST_DETACH = 2'd2
  } status_e;

  localparam logic ReqAlloc  = 1'b0;
  localparam logic ReqDetach = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] alloc_size;
    logic [16:0] alignment;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  buffer_index;
    logic [31:0] slice_offset;
    logic        opened_new;
    logic [31:0] new_capacity;
    logic [3:0]  released_count;
  } res_t;

  typedef struct packed {
    logic [31:0] cap;
    logic [31:0] fill;
  } entry_t;

endpackage

[sv/afsa_cell.sv]
// one table entry of the rotating buffer chain
module afsa_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  afsa_pkg::entry_t data_i,
  output afsa_pkg::entry_t data_o
);
  import afsa_pkg::*;

  entry_t entry_q;

  // entry moves one place along the ring on each shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= data_i;
    end
  end

  assign data_o = entry_q;

endmodule

[sv/afsa_rem.sv]
// bit-serial remainder unit, one quotient bit per cycle
module afsa_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [16:0] rem_o
);
  import afsa_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [16:0] rem_q;
  logic [17:0] trial;
  logic [17:0] diff;
  logic [16:0] rem_d;

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, divisor_i};
  assign rem_d = (trial >= {1'b0, divisor_i}) ? diff[16:0] : trial[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[sv/aligned_first_fit_slice_allocator.sv]
// top level of the aligned first-fit slice allocator
//
// usage: a request word is taken on req_i at a clock edge with start high and
// busy low. each request gives exactly one result word on res_o, marked by
// done_o for a single cycle; the receiver cannot stall and must take it then.
// an allocate scans the buffer table in index order: entries ride a ring of
// cells and the head entry is checked each step, so after MAX_BUFFERS steps
// the table is back in order. each open entry tested needs its fill rounded up
// to the alignment: the step state starts the bit-serial remainder unit, the
// divide state waits for the remainder and registers the rounded offset, and
// the test state checks the fit. an empty slot, or any entry after the slice
// is placed, is shifted on from the step state without a remainder. a detach
// shows its word in the next cycle. min_buffer_size is written through
// cfg_we_i / cfg_wdata_i; the user is to write it only while idle, as the block
// itself does not enforce this. reset empties the table, sets the minimum size
// to 65536 and leaves entry contents undefined; no clearing pass is run. the
// result word is registered, so the next request may be taken in the cycle its
// predecessor's result is shown.
module aligned_first_fit_slice_allocator #(
  parameter int unsigned MAX_BUFFERS = afsa_pkg::MaxBuffersDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  afsa_pkg::req_t req_i,
  output logic           done_o,
  output afsa_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);
  import afsa_pkg::*;

  localparam int unsigned SW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(MAX_BUFFERS + 1);
  localparam logic [SW-1:0] LastStep = SW'(MAX_BUFFERS - 1);
  localparam logic [CW-1:0] FullCount = CW'(MAX_BUFFERS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_TEST
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [SW-1:0] step_q;
  logic          found_q;
  logic          done_q;
  res_t          res_q;
  req_t          req_q;
  logic [16:0]   align_q;
  logic [31:0]   min_size_q;
  logic [32:0]   off_q;

  // ring of entry cells, head at index 0
  entry_t        cell_out [MAX_BUFFERS];
  entry_t        head;
  entry_t        ring_in;
  logic          shift_en;
  logic          hit;
  logic          open_new;
  logic [31:0]   cap_new;
  logic [33:0]   end_sum;
  logic          fit;
  logic          rem_start;
  logic          rem_done;
  logic [16:0]   rem;
  logic [32:0]   off_d;

  for (genvar k = 0; k < MAX_BUFFERS; k++) begin : g_cell
    entry_t cin;
    if (k == MAX_BUFFERS - 1) begin : g_tail
      assign cin = ring_in;
    end else begin : g_link
      assign cin = cell_out[k+1];
    end
    afsa_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_en),
      .data_i (cin),
      .data_o (cell_out[k])
    );
  end

  assign head = cell_out[0];

  afsa_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(head.fill),
    .divisor_i (align_q),
    .done_o    (rem_done),
    .rem_o     (rem)
  );

  // rounded offset: fill plus the gap up to the next multiple
  assign off_d = {1'b0, head.fill} + ((rem == 17'd0) ? 33'd0 : 33'(align_q - rem));
  assign end_sum = {1'b0, off_q} + {2'b0, req_q.alloc_size};
  assign fit     = end_sum <= {2'b0, head.cap};
  assign cap_new = (min_size_q > req_q.alloc_size) ? min_size_q : req_q.alloc_size;
  assign rem_start = (state_q == S_STEP) && !found_q && (CW'(step_q) < count_q);

  always_comb begin
    shift_en = 1'b0;
    ring_in  = head;
    hit      = 1'b0;
    open_new = 1'b0;
    case (state_q)
      S_STEP: begin
        if (!rem_start) begin
          shift_en = 1'b1;
          // first empty slot after a failed scan takes the new buffer
          if (!found_q && (CW'(step_q) == count_q)) begin
            open_new     = 1'b1;
            ring_in.cap  = cap_new;
            ring_in.fill = req_q.alloc_size;
          end
        end
      end
      S_TEST: begin
        shift_en = 1'b1;
        if (fit) begin
          hit          = 1'b1;
          ring_in.fill = end_sum[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      step_q     <= '0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      min_size_q <= MinSizeReset;
    end else begin
      // strobe after a detach is taken or after the last scan step
      done_q <= ((state_q == S_IDLE) && start && (req_i.req_type == ReqDetach)) ||
                (shift_en && (step_q == LastStep));
      if (cfg_we_i) begin
        min_size_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            align_q <= (req_i.alignment == 17'd0) ? 17'd1 : req_i.alignment;
            if (req_i.req_type == ReqDetach) begin
              res_q   <= '{status: ST_DETACH, buffer_index: 3'd0, slice_offset: 32'd0,
                           opened_new: 1'b0, new_capacity: 32'd0,
                           released_count: 4'(count_q)};
              count_q <= '0;
            end else begin
              res_q   <= '{status: ST_GRANT, buffer_index: 3'd0, slice_offset: 32'd0,
                           opened_new: 1'b0, new_capacity: 32'd0,
                           released_count: 4'd0};
              step_q  <= '0;
              found_q <= 1'b0;
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (rem_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            off_q   <= off_d;
            state_q <= S_TEST;
          end
        end
        S_TEST: ;
        default: state_q <= S_IDLE;
      endcase
      if (shift_en) begin
        if (hit) begin
          found_q            <= 1'b1;
          res_q.buffer_index <= 3'(step_q);
          res_q.slice_offset <= off_q[31:0];
        end
        if (open_new) begin
          found_q            <= 1'b1;
          count_q            <= count_q + 1'b1;
          res_q.buffer_index <= 3'(step_q);
          res_q.opened_new   <= 1'b1;
          res_q.new_capacity <= cap_new;
        end
        if (step_q == LastStep) begin
          state_q <= S_IDLE;
          if (!(found_q || hit || open_new)) begin
            res_q.status <= ST_NOSLOT;
          end
        end else begin
          step_q  <= step_q + 1'b1;
          state_q <= S_STEP;
        end
      end
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // table never holds more entries than cells
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("buffer count beyond table size");

  // a failed allocate only happens on a full table
  a_noslot_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_NOSLOT) |-> count_q == FullCount)
    else $error("no-slot reported with free entries");

  // a fit test always follows a finished remainder
  a_test_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> ($past(state_q) == S_DIV && $past(rem_done)))
    else $error("fit test without rounded offset");

  // the remainder unit is only started while no slice has been found
  a_start_unfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !found_q)
    else $error("remainder started after slice found");

endmodule
